// ===== design/b64enc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package b64enc_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int unsigned MAX_CHARS = 4;
  localparam int unsigned CNT_W = 3;

  // leftover pair counts
  localparam logic [1:0] PAIRS_NONE = 2'd0;
  localparam logic [1:0] PAIRS_TWO_BITS = 2'd1;
  localparam logic [1:0] PAIRS_FOUR_BITS = 2'd2;

  // register indexes
  localparam logic REG_URL_ALPHABET = 1'b0;
  localparam logic REG_PAD_OUTPUT = 1'b1;

  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [CNT_W-1:0]          count;
    logic                      last;
  } enc_group_t;

  typedef struct packed {
    logic url_alphabet;
    logic pad_output;
  } cfg_t;

  function automatic logic [7:0] map_group(input logic [5:0] g, input logic url);
    logic [7:0] ch;
    ch = 8'h00;
    case (g) inside
      [6'd0:6'd25]:  ch = 8'h41 + {2'b00, g};
      [6'd26:6'd51]: ch = 8'h61 + {2'b00, g} - 8'd26;
      [6'd52:6'd61]: ch = 8'h30 + {2'b00, g} - 8'd52;
      6'd62:         ch = url ? 8'h2D : 8'h2B;
      6'd63:         ch = url ? 8'h5F : 8'h2F;
      default:       ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== design/b64enc_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b64enc_regs
  import b64enc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.url_alphabet <= 1'b0;
      cfg.pad_output   <= 1'b1;
    end else if (wr_en) begin
      case (paddr[2])
        REG_URL_ALPHABET: cfg.url_alphabet <= pwdata[0];
        REG_PAD_OUTPUT:   cfg.pad_output   <= pwdata[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (paddr[2])
      REG_URL_ALPHABET: prdata = {31'd0, cfg.url_alphabet};
      REG_PAD_OUTPUT:   prdata = {31'd0, cfg.pad_output};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/b64enc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b64enc_core
  import b64enc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire cfg_t       cfg,
  output enc_group_t      grp
);

  logic [3:0] leftover_bits;
  logic [1:0] leftover_count;
  logic [3:0] leftover_bits_next;
  logic [1:0] leftover_count_next;
  logic [1:0] pairs;
  logic       url;

  assign url   = cfg.url_alphabet;
  assign pairs = (leftover_count == 2'd3) ? PAIRS_NONE : leftover_count;

  always_comb begin
    grp.chars = '0;
    grp.count = 3'd1;
    grp.last  = last_byte;
    leftover_bits_next  = 4'd0;
    leftover_count_next = PAIRS_NONE;
    case (pairs)
      PAIRS_NONE: begin
        grp.chars[0] = map_group(data_byte[7:2], url);
        leftover_bits_next  = {2'b00, data_byte[1:0]};
        leftover_count_next = PAIRS_TWO_BITS;
        if (last_byte) begin
          grp.chars[1] = map_group({data_byte[1:0], 4'b0000}, url);
          grp.chars[2] = PAD_CHAR;
          grp.chars[3] = PAD_CHAR;
          grp.count    = cfg.pad_output ? 3'd4 : 3'd2;
        end
      end
      PAIRS_TWO_BITS: begin
        grp.chars[0] = map_group({leftover_bits[1:0], data_byte[7:4]}, url);
        leftover_bits_next  = data_byte[3:0];
        leftover_count_next = PAIRS_FOUR_BITS;
        if (last_byte) begin
          grp.chars[1] = map_group({data_byte[3:0], 2'b00}, url);
          grp.chars[2] = PAD_CHAR;
          grp.count    = cfg.pad_output ? 3'd3 : 3'd2;
        end
      end
      default: begin
        grp.chars[0] = map_group({leftover_bits, data_byte[7:6]}, url);
        grp.chars[1] = map_group(data_byte[5:0], url);
        grp.count    = 3'd2;
      end
    endcase
    if (last_byte) begin
      leftover_bits_next  = 4'd0;
      leftover_count_next = PAIRS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= 4'd0;
      leftover_count <= PAIRS_NONE;
    end else if (accept) begin
      leftover_bits  <= leftover_bits_next;
      leftover_count <= leftover_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/b64enc_outbuf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b64enc_outbuf
  import b64enc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire enc_group_t grp_in,
  output logic            can_load,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast
);

  enc_group_t grp;
  logic [1:0] idx;
  logic       busy;
  logic       final_char;
  logic       out_xfer;

  assign final_char = (({1'b0, idx} + 3'd1) == grp.count);
  assign out_xfer   = busy && m_tready;
  assign can_load   = !busy || (out_xfer && final_char);

  assign m_tvalid = busy;
  assign m_tdata  = grp.chars[idx];
  assign m_tlast  = grp.last && final_char;

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (out_xfer) begin
      if (final_char) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/base64_stream_encoder.sv =====
// base64 stream encoder
// input stream: one message byte per transfer on s_tdata, s_tlast marks the
// last byte of a message. output stream: one ascii character per transfer on
// m_tdata, m_tlast marks the final character of the message.
// each byte yields one or two characters, a last byte up to four (flush plus
// '=' padding when pad_output is set).
// the first character of a byte is offered on m_tvalid in the cycle
// after the byte transfer. throughput: one character per cycle while
// m_tready is high. the character buffer drains one entry per cycle while
// m_tready is high and takes the next byte in the cycle its final
// character leaves.
// a stalled receiver holds the current character and s_tready stays low
// until the buffer is down to its final character being taken.
// reset clears the pending bits and the buffer and sets url_alphabet to 0,
// pad_output to 1. config via apb: url_alphabet at 0x0, pad_output at 0x4,
// to be written by the user only while the encoder is idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder
  import b64enc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_char
  output logic             m_tlast,   // end_of_message
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  enc_group_t grp;
  logic       accept;
  logic       can_load;

  assign s_tready = can_load;
  assign accept   = s_tvalid && s_tready;

  b64enc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  b64enc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .cfg       (cfg),
    .grp       (grp)
  );

  b64enc_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .grp_in   (grp),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input not ready with empty buffer");

  a_valid_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("no character after byte transfer");

  a_free_on_final: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |-> s_tready)
    else $error("buffer not freed on final character");

  a_group_count: assert property (@(posedge clk) disable iff (rst)
    accept |-> (grp.count != 3'd0) && (grp.count <= 3'd4))
    else $error("bad character count");

endmodule

`default_nettype wire
